### sv/cbsu_pkg.sv
// Shared types and constants of the CB-prefix bit and shift unit.
package cbsu_pkg;

  localparam int unsigned NumRegs = 7;

  // Operand select codes (opcode bits 2:0) and register slots
  localparam logic [2:0] SEL_MEM  = 3'd6;
  localparam logic [2:0] SEL_A    = 3'd7;
  localparam logic [2:0] SLOT_H   = 3'd4;
  localparam logic [2:0] SLOT_L   = 3'd5;
  localparam logic [2:0] SLOT_A   = 3'd6;
  localparam logic [2:0] LD_FLAGS = 3'd6;

  // Cycle costs
  localparam logic [4:0] COST_LOAD  = 5'd0;
  localparam logic [4:0] COST_REG   = 5'd8;
  localparam logic [4:0] COST_BIT_M = 5'd12;
  localparam logic [4:0] COST_MEM   = 5'd16;

  typedef enum logic [1:0] {
    GRP_SHIFT = 2'd0,
    GRP_BIT   = 2'd1,
    GRP_RES   = 2'd2,
    GRP_SET   = 2'd3
  } grp_e;

  typedef enum logic [2:0] {
    SH_RLC  = 3'd0,
    SH_RRC  = 3'd1,
    SH_RL   = 3'd2,
    SH_RR   = 3'd3,
    SH_SLA  = 3'd4,
    SH_SRA  = 3'd5,
    SH_SWAP = 3'd6,
    SH_SRL  = 3'd7
  } shift_e;

  typedef enum logic {
    REQ_EXEC = 1'b0,
    REQ_LOAD = 1'b1
  } req_e;

  // Flag nibble: bit3 Z, bit2 N, bit1 H, bit0 C
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] opcode;
    logic [7:0] mem_data;
    logic [2:0] reg_index;
    logic [7:0] reg_value;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] mem_addr;
    logic        mem_used;
    logic        mem_write;
    logic [7:0]  result_byte;
    logic        flag_zero;
    logic        flag_subtract;
    logic        flag_half;
    logic        flag_carry;
    logic [4:0]  cycle_cost;
  } out_beat_t;

  // Register file update from the execute stage
  typedef struct packed {
    logic       en;
    logic [2:0] slot;
    logic [7:0] value;
  } reg_wr_t;

endpackage

### sv/cbsu_if.sv
// Valid/ready channel interfaces for request and result beats.
interface cbsu_in_if import cbsu_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cbsu_out_if import cbsu_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/cb_prefix_bit_shift_unit.sv
// Top level of the CB-prefix bit and shift unit: stage registers and CPU state.
//
// Usage:
//   req_i carries one request beat: either a CB opcode to execute (with the
//   byte read at HL in mem_data) or a load of a register or of the flag nibble.
//   rsp_o returns one result beat per request, in order: the HL address, memory
//   use and write strobes, the result byte, the four flags and the cycle cost.
//   A request beat is held in the request register, then the execute logic
//   feeds the result register.
//   Throughput is one beat per cycle while the receiver takes results; the
//   execute step reads and updates the seven registers and the flags as the
//   beat moves to the result register, so consecutive beats chain with no bubble.
//   When the receiver stalls, the result register holds its beat, the request
//   register fills, and req_i.ready drops until the result is taken.
//   Reset clears B, C, D, E, H, L, A and the flags to zero and empties both
//   stage registers.
module cb_prefix_bit_shift_unit import cbsu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  cbsu_in_if.sink      req_i,
  cbsu_out_if.source   rsp_o
);

  in_beat_t   in_q;
  logic       in_valid_q;
  out_beat_t  out_q;
  out_beat_t  out_d;
  logic       out_valid_q;
  logic [7:0] regs_q [NumRegs];
  flags_t     flags_q;
  flags_t     flags_d;
  reg_wr_t    reg_wr;
  logic       advance;
  logic       take_in;

  // Move a beat to the result register when it is empty or being drained
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign take_in     = req_i.valid && req_i.ready;

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  cbsu_exec u_exec (
    .beat_i   (in_q),
    .regs_i   (regs_q),
    .flags_i  (flags_q),
    .result_o (out_d),
    .reg_wr_o (reg_wr),
    .flags_o  (flags_d)
  );

  // Hold stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_in) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_q <= req_i.data;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // Update registers and flags as each beat executes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= 8'h00;
      end
      flags_q <= '0;
    end else if (advance) begin
      flags_q <= flags_d;
      if (reg_wr.en) begin
        regs_q[reg_wr.slot] <= reg_wr.value;
      end
    end
  end

  a_write_needs_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.mem_write |-> rsp_o.data.mem_used)
    else $error("memory write without memory operand");

  a_write_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.mem_write |-> rsp_o.data.cycle_cost == COST_MEM)
    else $error("memory write with wrong cycle cost");

  a_load_no_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.cycle_cost == COST_LOAD |->
      !rsp_o.data.mem_used && !rsp_o.data.mem_write)
    else $error("load result reports memory access");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("executed beat did not reach the result register");

endmodule

### sv/cbsu_exec.sv
// Combinational execute logic: operand fetch, shift/bit ops, flags and writeback.
module cbsu_exec import cbsu_pkg::*; (
  input  in_beat_t   beat_i,
  input  logic [7:0] regs_i [NumRegs],
  input  flags_t     flags_i,
  output out_beat_t  result_o,
  output reg_wr_t    reg_wr_o,
  output flags_t     flags_o
);

  logic [2:0] sel;
  logic [2:0] slot;
  logic [2:0] ld_slot;
  logic       is_mem;
  logic [7:0] operand;
  logic [7:0] mask;
  logic [7:0] shifted;
  logic       sh_carry;
  grp_e       grp;
  shift_e     kind;

  assign sel     = beat_i.opcode[2:0];
  assign grp     = grp_e'(beat_i.opcode[7:6]);
  assign kind    = shift_e'(beat_i.opcode[5:3]);
  assign slot    = (sel == SEL_A) ? SLOT_A : sel;
  assign ld_slot = (beat_i.reg_index == SEL_A) ? SLOT_A : beat_i.reg_index;
  assign is_mem  = (sel == SEL_MEM);
  assign operand = is_mem ? beat_i.mem_data : regs_i[slot];
  assign mask    = 8'(8'h01 << beat_i.opcode[5:3]);

  // Shift and rotate unit
  always_comb begin
    shifted  = operand;
    sh_carry = 1'b0;
    case (kind)
      SH_RLC: begin
        shifted  = {operand[6:0], operand[7]};
        sh_carry = operand[7];
      end
      SH_RRC: begin
        shifted  = {operand[0], operand[7:1]};
        sh_carry = operand[0];
      end
      SH_RL: begin
        shifted  = {operand[6:0], flags_i.c};
        sh_carry = operand[7];
      end
      SH_RR: begin
        shifted  = {flags_i.c, operand[7:1]};
        sh_carry = operand[0];
      end
      SH_SLA: begin
        shifted  = {operand[6:0], 1'b0};
        sh_carry = operand[7];
      end
      SH_SRA: begin
        shifted  = {operand[7], operand[7:1]};
        sh_carry = operand[0];
      end
      SH_SWAP: begin
        shifted  = {operand[3:0], operand[7:4]};
        sh_carry = 1'b0;
      end
      default: begin
        shifted  = {1'b0, operand[7:1]};
        sh_carry = operand[0];
      end
    endcase
  end

  // Result, flags and register update
  always_comb begin
    flags_o              = flags_i;
    reg_wr_o             = '0;
    result_o             = '0;
    result_o.mem_addr    = {regs_i[SLOT_H], regs_i[SLOT_L]};
    if (beat_i.req_type == REQ_LOAD) begin
      result_o.cycle_cost = COST_LOAD;
      if (beat_i.reg_index == LD_FLAGS) begin
        flags_o              = flags_t'(beat_i.reg_value[3:0]);
        result_o.result_byte = {4'h0, beat_i.reg_value[3:0]};
      end else begin
        reg_wr_o.en          = 1'b1;
        reg_wr_o.slot        = ld_slot;
        reg_wr_o.value       = beat_i.reg_value;
        result_o.result_byte = beat_i.reg_value;
      end
    end else begin
      unique case (grp)
        GRP_SHIFT: begin
          result_o.result_byte = shifted;
          flags_o              = '{z: (shifted == 8'h00), n: 1'b0, h: 1'b0, c: sh_carry};
        end
        GRP_BIT: begin
          result_o.result_byte = operand;
          flags_o              = '{z: ((operand & mask) == 8'h00), n: 1'b0, h: 1'b1,
                                   c: flags_i.c};
        end
        GRP_RES: result_o.result_byte = operand & ~mask;
        default: result_o.result_byte = operand | mask;
      endcase
      if (is_mem) begin
        result_o.mem_used   = 1'b1;
        result_o.mem_write  = (grp != GRP_BIT);
        result_o.cycle_cost = (grp == GRP_BIT) ? COST_BIT_M : COST_MEM;
      end else begin
        result_o.cycle_cost = COST_REG;
        reg_wr_o.en         = (grp != GRP_BIT);
        reg_wr_o.slot       = slot;
        reg_wr_o.value      = result_o.result_byte;
      end
    end
    result_o.flag_zero     = flags_o.z;
    result_o.flag_subtract = flags_o.n;
    result_o.flag_half     = flags_o.h;
    result_o.flag_carry    = flags_o.c;
  end

endmodule
